// File: design/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg
// Types, codes and constants shared by the 48-bit LCG random draw unit.
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam int unsigned StateW   = 48;
  localparam int unsigned DrawW    = 31;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned CountW   = 6;
  localparam int unsigned BoundW   = 32;
  localparam int unsigned HalfW    = 24;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 64;
  localparam int unsigned TriesW   = 7;
  localparam int unsigned DivCntW  = 5;

  localparam logic [StateW-1:0] ResetMultiplier = 48'd25214903917;
  localparam logic [StateW-1:0] ResetAddend     = 48'd11;
  localparam logic [StateW-1:0] ResetSeed       = 48'd0;
  localparam logic [TriesW-1:0] MaxTries        = 7'd64;

  typedef enum logic [CmdW-1:0] {
    CMD_BITS    = 3'd0,
    CMD_BOUNDED = 3'd1,
    CMD_LONG    = 3'd2,
    CMD_FRAC    = 3'd3,
    CMD_RESEED  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MULT   = 2'd0,
    REG_ADDEND = 2'd1,
    REG_SEED   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL,
    MUL_WR
  } mul_op_e;

  typedef enum logic [1:0] {
    HI_NONE,
    HI_32,
    HI_26
  } hi_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_BAD,
    RES_BITS,
    RES_LONG,
    RES_FRAC,
    RES_POW,
    RES_MOD
  } res_op_e;

  typedef struct packed {
    logic    latch;
    mul_op_e mul;
    logic    reseed;
    hi_op_e  hi;
    logic    pow_mul;
    logic    div_load;
    logic    div_step;
    res_op_e res;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic pow2;
    logic div_last;
    logic reject;
    logic tries_full;
  } dp_sts_t;

endpackage

// File: design/lcg48_in_if.sv
// ----------------------------------------------------------------------------
// lcg48_in_if
// Command channel of the draw unit: valid/ready with one command per transfer.
// ----------------------------------------------------------------------------
interface lcg48_in_if;
  logic                              valid;
  logic                              ready;
  logic [lcg48_pkg::CmdW-1:0]        cmd;
  logic [lcg48_pkg::CountW-1:0]      bit_count;
  logic signed [lcg48_pkg::BoundW-1:0] upper_bound;

  modport source (output valid, cmd, bit_count, upper_bound, input ready);
  modport sink   (input valid, cmd, bit_count, upper_bound, output ready);
endinterface

// File: design/lcg48_out_if.sv
// ----------------------------------------------------------------------------
// lcg48_out_if
// Result channel of the draw unit: valid/ready with one result per transfer.
// ----------------------------------------------------------------------------
interface lcg48_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcg48_pkg::ValueW-1:0] value;
  logic                                bad_bound;

  modport source (output valid, value, bad_bound, input ready);
  modport sink   (input valid, value, bad_bound, output ready);
endinterface

// File: design/lcg48_regs.sv
// ----------------------------------------------------------------------------
// lcg48_regs
// APB-style configuration registers: multiplier, addend and seed.
// ----------------------------------------------------------------------------
module lcg48_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcg48_pkg::PaddrW-1:0]      paddr,
  input  logic [lcg48_pkg::PdataW-1:0]      pwdata,
  output logic [lcg48_pkg::PdataW-1:0]      prdata,
  output logic                              pready,
  output logic [lcg48_pkg::StateW-1:0]      mult_o,
  output logic [lcg48_pkg::StateW-1:0]      addend_o,
  output logic [lcg48_pkg::StateW-1:0]      seed_o
);

  logic [lcg48_pkg::StateW-1:0] mult_q, addend_q, seed_q;
  lcg48_pkg::reg_idx_e          idx;
  logic                         wr_en;

  // Registers sit on 8-byte boundaries, so the index is taken above bit 2.
  assign idx    = lcg48_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q   <= lcg48_pkg::ResetMultiplier;
      addend_q <= lcg48_pkg::ResetAddend;
      seed_q   <= lcg48_pkg::ResetSeed;
    end else if (wr_en) begin
      unique case (idx)
        lcg48_pkg::REG_MULT:   mult_q   <= pwdata[lcg48_pkg::StateW-1:0];
        lcg48_pkg::REG_ADDEND: addend_q <= pwdata[lcg48_pkg::StateW-1:0];
        lcg48_pkg::REG_SEED:   seed_q   <= pwdata[lcg48_pkg::StateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lcg48_pkg::REG_MULT:   prdata = {16'd0, mult_q};
      lcg48_pkg::REG_ADDEND: prdata = {16'd0, addend_q};
      lcg48_pkg::REG_SEED:   prdata = {16'd0, seed_q};
      default:               prdata = '0;
    endcase
  end

  assign mult_o   = mult_q;
  assign addend_o = addend_q;
  assign seed_o   = seed_q;

endmodule

// File: design/lcg48_dp.sv
// ----------------------------------------------------------------------------
// lcg48_dp
// Datapath: generator state, shared 24x24 multiplier, bounded-draw divider
// and the result and output registers.
// ----------------------------------------------------------------------------
module lcg48_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lcg48_pkg::dp_cmd_t                cmd_i,
  output lcg48_pkg::dp_sts_t                sts_o,
  input  logic [lcg48_pkg::CountW-1:0]      bit_count_i,
  input  logic [lcg48_pkg::BoundW-1:0]      upper_bound_i,
  input  logic [lcg48_pkg::StateW-1:0]      mult_i,
  input  logic [lcg48_pkg::StateW-1:0]      addend_i,
  input  logic [lcg48_pkg::StateW-1:0]      seed_i,
  output logic [lcg48_pkg::ValueW-1:0]      value_o,
  output logic                              bad_bound_o
);

  logic [lcg48_pkg::StateW-1:0]  state_q, prod_q, acc_q, aligned;
  logic                          prod_hi_q;
  logic [lcg48_pkg::HalfW-1:0]   mul_a, mul_b;
  logic [lcg48_pkg::StateW-1:0]  mul_p;
  logic [lcg48_pkg::CountW-1:0]  k_q, k_sat, shamt;
  logic [lcg48_pkg::StateW-1:0]  top;
  logic [lcg48_pkg::DrawW-1:0]   bound_q, draw31, bits_q, dvd_q;
  logic [lcg48_pkg::WordW-1:0]   hi_q, rem_q, rem_t, chk;
  logic [61:0]                   pw_q;
  logic [lcg48_pkg::DivCntW-1:0] cnt_q;
  logic [lcg48_pkg::TriesW-1:0]  tries_q;
  logic [lcg48_pkg::ValueW-1:0]  res_q, out_value_q;
  logic                          res_bad_q, out_bad_q;

  assign draw31 = state_q[47:17];
  assign k_sat  = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
  assign shamt  = 6'd48 - k_q;
  assign top    = state_q >> shamt;

  // Partial products: the high-by-high term falls outside 48 bits.
  always_comb begin
    case (cmd_i.mul)
      lcg48_pkg::MUL_LH: begin
        mul_a = state_q[23:0];
        mul_b = mult_i[47:24];
      end
      lcg48_pkg::MUL_HL: begin
        mul_a = state_q[47:24];
        mul_b = mult_i[23:0];
      end
      default: begin
        mul_a = state_q[23:0];
        mul_b = mult_i[23:0];
      end
    endcase
  end

  assign mul_p   = {24'd0, mul_a} * {24'd0, mul_b};
  assign aligned = prod_hi_q ? {prod_q[23:0], 24'd0} : prod_q;

  // One restoring division step; the remainder stays below the bound.
  assign rem_t = {rem_q[30:0], dvd_q[30]};
  assign chk   = {1'b0, bits_q} - rem_q + {1'b0, bound_q} - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcg48_pkg::ResetMultiplier ^ lcg48_pkg::ResetSeed;
      tries_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.reseed) begin
        state_q <= seed_i ^ mult_i;
      end else if (cmd_i.mul == lcg48_pkg::MUL_WR) begin
        state_q <= acc_q + aligned;
      end
      if (cmd_i.latch) begin
        tries_q <= '0;
      end else if (cmd_i.mul == lcg48_pkg::MUL_WR) begin
        tries_q <= tries_q + 7'd1;
      end
      if (cmd_i.div_load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      k_q     <= k_sat;
      bound_q <= upper_bound_i[30:0];
    end
    case (cmd_i.mul) inside
      lcg48_pkg::MUL_LL: begin
        prod_q    <= mul_p;
        prod_hi_q <= 1'b0;
        acc_q     <= addend_i;
      end
      lcg48_pkg::MUL_LH, lcg48_pkg::MUL_HL: begin
        prod_q    <= mul_p;
        prod_hi_q <= 1'b1;
        acc_q     <= acc_q + aligned;
      end
      default: ;
    endcase
    case (cmd_i.hi)
      lcg48_pkg::HI_32: hi_q <= state_q[47:16];
      lcg48_pkg::HI_26: hi_q <= {6'd0, state_q[47:22]};
      default: ;
    endcase
    if (cmd_i.pow_mul) begin
      pw_q <= {31'd0, bound_q} * {31'd0, draw31};
    end
    if (cmd_i.div_load) begin
      bits_q <= draw31;
      dvd_q  <= draw31;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[29:0], 1'b0};
      rem_q <= (rem_t >= {1'b0, bound_q}) ? (rem_t - {1'b0, bound_q}) : rem_t;
    end
    case (cmd_i.res)
      lcg48_pkg::RES_ZERO: begin
        res_q     <= '0;
        res_bad_q <= 1'b0;
      end
      lcg48_pkg::RES_BAD: begin
        res_q     <= '0;
        res_bad_q <= 1'b1;
      end
      lcg48_pkg::RES_BITS: begin
        res_q     <= {{32{top[31]}}, top[31:0]};
        res_bad_q <= 1'b0;
      end
      lcg48_pkg::RES_LONG: begin
        res_q     <= {hi_q, 32'd0} + {{32{state_q[47]}}, state_q[47:16]};
        res_bad_q <= 1'b0;
      end
      lcg48_pkg::RES_FRAC: begin
        res_q     <= {11'd0, hi_q[25:0], state_q[47:21]};
        res_bad_q <= 1'b0;
      end
      lcg48_pkg::RES_POW: begin
        res_q     <= {33'd0, pw_q[61:31]};
        res_bad_q <= 1'b0;
      end
      lcg48_pkg::RES_MOD: begin
        res_q     <= {32'd0, rem_q};
        res_bad_q <= 1'b0;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_value_q <= res_q;
      out_bad_q   <= res_bad_q;
    end
  end

  assign sts_o.in_bad     = upper_bound_i[31] || (upper_bound_i == 32'd0);
  assign sts_o.pow2       = ((bound_q & (bound_q - 31'd1)) == 31'd0);
  assign sts_o.div_last   = (cnt_q == 5'd30);
  assign sts_o.reject     = chk[31];
  assign sts_o.tries_full = (tries_q == lcg48_pkg::MaxTries);

  assign value_o     = out_value_q;
  assign bad_bound_o = out_bad_q;

endmodule

// File: design/lcg48_ctrl.sv
// ----------------------------------------------------------------------------
// lcg48_ctrl
// Controller: sequences generator steps, draws and the output handshake.
// ----------------------------------------------------------------------------
module lcg48_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [lcg48_pkg::CmdW-1:0]  in_cmd_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  lcg48_pkg::dp_sts_t          sts_i,
  output lcg48_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL_LL = 10'b00_0000_0010,
    ST_MUL_LH = 10'b00_0000_0100,
    ST_MUL_HL = 10'b00_0000_1000,
    ST_MUL_WR = 10'b00_0001_0000,
    ST_USE    = 10'b00_0010_0000,
    ST_POW    = 10'b00_0100_0000,
    ST_DIV    = 10'b00_1000_0000,
    ST_CHECK  = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  lcg48_pkg::cmd_e   op_q, op_d;
  logic              phase_q, phase_d;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          op_d        = lcg48_pkg::cmd_e'(in_cmd_i);
          phase_d     = 1'b0;
          unique case (lcg48_pkg::cmd_e'(in_cmd_i)) inside
            lcg48_pkg::CMD_BITS, lcg48_pkg::CMD_LONG, lcg48_pkg::CMD_FRAC: begin
              state_d = ST_MUL_LL;
            end
            lcg48_pkg::CMD_BOUNDED: begin
              if (sts_i.in_bad) begin
                cmd_o.res = lcg48_pkg::RES_BAD;
                state_d   = ST_OUT;
              end else begin
                state_d = ST_MUL_LL;
              end
            end
            lcg48_pkg::CMD_RESEED: begin
              cmd_o.reseed = 1'b1;
              cmd_o.res    = lcg48_pkg::RES_ZERO;
              state_d      = ST_OUT;
            end
            default: begin
              cmd_o.res = lcg48_pkg::RES_ZERO;
              state_d   = ST_OUT;
            end
          endcase
        end
      end
      ST_MUL_LL: begin
        cmd_o.mul = lcg48_pkg::MUL_LL;
        state_d   = ST_MUL_LH;
      end
      ST_MUL_LH: begin
        cmd_o.mul = lcg48_pkg::MUL_LH;
        state_d   = ST_MUL_HL;
      end
      ST_MUL_HL: begin
        cmd_o.mul = lcg48_pkg::MUL_HL;
        state_d   = ST_MUL_WR;
      end
      ST_MUL_WR: begin
        cmd_o.mul = lcg48_pkg::MUL_WR;
        state_d   = ST_USE;
      end
      ST_USE: begin
        unique case (op_q)
          lcg48_pkg::CMD_BITS: begin
            cmd_o.res = lcg48_pkg::RES_BITS;
            state_d   = ST_OUT;
          end
          lcg48_pkg::CMD_LONG: begin
            if (!phase_q) begin
              cmd_o.hi = lcg48_pkg::HI_32;
              phase_d  = 1'b1;
              state_d  = ST_MUL_LL;
            end else begin
              cmd_o.res = lcg48_pkg::RES_LONG;
              state_d   = ST_OUT;
            end
          end
          lcg48_pkg::CMD_FRAC: begin
            if (!phase_q) begin
              cmd_o.hi = lcg48_pkg::HI_26;
              phase_d  = 1'b1;
              state_d  = ST_MUL_LL;
            end else begin
              cmd_o.res = lcg48_pkg::RES_FRAC;
              state_d   = ST_OUT;
            end
          end
          lcg48_pkg::CMD_BOUNDED: begin
            if (sts_i.pow2) begin
              cmd_o.pow_mul = 1'b1;
              state_d       = ST_POW;
            end else begin
              cmd_o.div_load = 1'b1;
              state_d        = ST_DIV;
            end
          end
          default: begin
            cmd_o.res = lcg48_pkg::RES_ZERO;
            state_d   = ST_OUT;
          end
        endcase
      end
      ST_POW: begin
        cmd_o.res = lcg48_pkg::RES_POW;
        state_d   = ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A rejected draw is redrawn until the try limit is reached.
        if (sts_i.reject && !sts_i.tries_full) begin
          state_d = ST_MUL_LL;
        end else begin
          cmd_o.res = lcg48_pkg::RES_MOD;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= lcg48_pkg::CMD_BITS;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/lcg48_random_draw_unit.sv
// ----------------------------------------------------------------------------
// lcg48_random_draw_unit
// 48-bit linear congruential generator with bits, bounded, long, fraction
// and reseed commands; one result per command.
// ----------------------------------------------------------------------------
// Each generator step runs on the shared 24x24 multiplier through the
// states ST_MUL_LL, ST_MUL_LH, ST_MUL_HL and ST_MUL_WR. A bound that is
// not a power of two uses a restoring division, with up to 64 tries. One
// command is in flight at a time.
// Reset is asynchronous and active low; the state resets to 25214903917.
module lcg48_random_draw_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lcg48_in_if.sink                      req_i,
  lcg48_out_if.source                   rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcg48_pkg::PaddrW-1:0]  paddr,
  input  logic [lcg48_pkg::PdataW-1:0]  pwdata,
  output logic [lcg48_pkg::PdataW-1:0]  prdata,
  output logic                          pready
);

  logic [lcg48_pkg::StateW-1:0] mult, addend, seed;
  lcg48_pkg::dp_cmd_t           dp_cmd;
  lcg48_pkg::dp_sts_t           dp_sts;
  logic [lcg48_pkg::ValueW-1:0] value;

  lcg48_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .mult_o   (mult),
    .addend_o (addend),
    .seed_o   (seed)
  );

  lcg48_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_cmd_i    (req_i.cmd),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  lcg48_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .bit_count_i   (req_i.bit_count),
    .upper_bound_i (req_i.upper_bound),
    .mult_i        (mult),
    .addend_i      (addend),
    .seed_i        (seed),
    .value_o       (value),
    .bad_bound_o   (rsp_o.bad_bound)
  );

  assign rsp_o.value = value;

endmodule
